### design/gbil_pkg.sv
`default_nettype none

package gbil_pkg;

   // Field widths of the transaction payloads.
   localparam int unsigned FIELD_PINS      = 12;
   localparam int unsigned DATA_WIDTH      = 32;
   localparam int unsigned TYPE_HIGH_WIDTH = 16;
   localparam int unsigned MUX_WIDTH       = 7;
   localparam int unsigned PIN_COUNT_DEF   = 12;

   // Transaction kinds. The unused code behaves as an idle tick.
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_IDLE  = 2'd2;

   // Register map.
   localparam logic [2:0] REG_INPUT    = 3'd0;
   localparam logic [2:0] REG_OUT      = 3'd1;
   localparam logic [2:0] REG_OUT_EN   = 3'd2;
   localparam logic [2:0] REG_INT_STAT = 3'd3;
   localparam logic [2:0] REG_INT_EN   = 3'd4;
   localparam logic [2:0] REG_TYPE0    = 3'd5;
   localparam logic [2:0] REG_TYPE1    = 3'd6;
   localparam logic [2:0] REG_MUX      = 3'd7;

   typedef struct packed {
      logic [1:0]            kind;
      logic [2:0]            reg_index;
      logic [DATA_WIDTH-1:0] write_data;
      logic [FIELD_PINS-1:0] pin_levels;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_data;
      logic [FIELD_PINS-1:0] pins_drive;
      logic [FIELD_PINS-1:0] pins_drive_enable;
      logic                  irq_line;
   } rsp_type;

endpackage

`default_nettype wire

### design/gbil_regs.sv
`default_nettype none

module gbil_regs
   import gbil_pkg::*;
#(
   parameter int unsigned PIN_COUNT = PIN_COUNT_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step_en,
   input  wire req_type req,
   output rsp_type      rsp_next
);

   localparam int unsigned TYPE_ALL_WIDTH = 64;

   logic [PIN_COUNT-1:0]       out_ff, out_in;
   logic [PIN_COUNT-1:0]       oen_ff, oen_in;
   logic [PIN_COUNT-1:0]       stat_ff, stat_in;
   logic [PIN_COUNT-1:0]       ien_ff, ien_in;
   logic [DATA_WIDTH-1:0]      type_low_ff, type_low_in;
   logic [TYPE_HIGH_WIDTH-1:0] type_high_ff, type_high_in;
   logic [MUX_WIDTH-1:0]       mux_ff, mux_in;

   logic [PIN_COUNT-1:0]      levels;
   logic [PIN_COUNT-1:0]      active;
   logic [PIN_COUNT-1:0]      stat_cleared;
   logic [TYPE_ALL_WIDTH-1:0] type_all;
   logic                      is_write;
   logic [DATA_WIDTH-1:0]     read_value;

   // Pin levels of this transaction, pins beyond the sampled field read as zero.
   for (genvar i = 0; i < PIN_COUNT; i++) begin : g_levels
      if (i < FIELD_PINS) begin : g_have
         assign levels[i] = req.pin_levels[i];
      end else begin : g_none
         assign levels[i] = 1'b0;
      end
   end

   // Register writes, applied before the pin sample is taken.
   assign is_write = (req.kind == KIND_WRITE);

   always_comb begin
      out_in       = out_ff;
      oen_in       = oen_ff;
      stat_cleared = stat_ff;
      ien_in       = ien_ff;
      type_low_in  = type_low_ff;
      type_high_in = type_high_ff;
      mux_in       = mux_ff;
      if (is_write) begin
         unique case (req.reg_index)
            REG_OUT:      out_in       = req.write_data[PIN_COUNT-1:0];
            REG_OUT_EN:   oen_in       = req.write_data[PIN_COUNT-1:0];
            REG_INT_STAT: stat_cleared = stat_ff & ~req.write_data[PIN_COUNT-1:0];
            REG_INT_EN:   ien_in       = req.write_data[PIN_COUNT-1:0];
            REG_TYPE0:    type_low_in  = req.write_data;
            REG_TYPE1:    type_high_in = req.write_data[TYPE_HIGH_WIDTH-1:0];
            REG_MUX:      mux_in       = req.write_data[MUX_WIDTH-1:0];
            default:      ;
         endcase
      end
   end

   // Active level per pin: bit 0 of the type nibble selects low-active.
   assign type_all = {{(TYPE_ALL_WIDTH - DATA_WIDTH - TYPE_HIGH_WIDTH){1'b0}},
                      type_high_in, type_low_in};

   for (genvar i = 0; i < PIN_COUNT; i++) begin : g_active
      assign active[i] = levels[i] ^ type_all[4*i];
   end

   assign stat_in = stat_cleared | active;

   // Read mux sees the registers as they stand before this transaction.
   always_comb begin
      read_value = '0;
      unique case (req.reg_index)
         REG_INPUT:    read_value = DATA_WIDTH'(levels);
         REG_OUT:      read_value = DATA_WIDTH'(out_ff);
         REG_OUT_EN:   read_value = DATA_WIDTH'(oen_ff);
         REG_INT_STAT: read_value = DATA_WIDTH'(stat_ff);
         REG_INT_EN:   read_value = DATA_WIDTH'(ien_ff);
         REG_TYPE0:    read_value = type_low_ff;
         REG_TYPE1:    read_value = DATA_WIDTH'(type_high_ff);
         REG_MUX:      read_value = DATA_WIDTH'(mux_ff);
         default:      read_value = '0;
      endcase
   end

   assign rsp_next.read_data = (req.kind == KIND_READ) ? read_value : '0;
   assign rsp_next.irq_line  = |(stat_in & ien_in);

   // Pin outputs are the fixed field width, extended or trimmed from the bank.
   for (genvar i = 0; i < FIELD_PINS; i++) begin : g_drive
      if (i < PIN_COUNT) begin : g_have
         assign rsp_next.pins_drive[i]        = out_in[i];
         assign rsp_next.pins_drive_enable[i] = oen_in[i];
      end else begin : g_none
         assign rsp_next.pins_drive[i]        = 1'b0;
         assign rsp_next.pins_drive_enable[i] = 1'b0;
      end
   end

   // State update, one transaction per enabled cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff       <= '0;
         oen_ff       <= '0;
         stat_ff      <= '0;
         ien_ff       <= '0;
         type_low_ff  <= '0;
         type_high_ff <= '0;
         mux_ff       <= '0;
      end else if (step_en) begin
         out_ff       <= out_in;
         oen_ff       <= oen_in;
         stat_ff      <= stat_in;
         ien_ff       <= ien_in;
         type_low_ff  <= type_low_in;
         type_high_ff <= type_high_in;
         mux_ff       <= mux_in;
      end
   end

endmodule

`default_nettype wire

### design/gpio_bank_with_level_irq_latch.sv
// A transaction waits in the input register and its result in the result register.
// Throughput: one transaction per cycle unless stalled; the input and result registers
// let a new transaction enter while a finished result still waits for rsp_ready.
// Reset (synchronous, active high) clears the valid flags and bank registers: pins
// are inputs, interrupts are masked and cleared, all pins are level-high, mux is zero.
`default_nettype none

module gpio_bank_with_level_irq_latch
   import gbil_pkg::*;
#(
   parameter int unsigned PIN_COUNT = PIN_COUNT_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_req_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_next;
   logic    step;

   // The held transaction moves on when the result register is free or emptying.
   assign step      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || step;

   assign s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff <= req_data;
      end
   end

   // Register bank and its update logic.
   gbil_regs #(
      .PIN_COUNT(PIN_COUNT)
   ) u_regs (
      .clock   (clock),
      .reset   (reset),
      .step_en (step),
      .req     (s1_req_ff),
      .rsp_next(rsp_next)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks on the pipeline control.
   a_no_result_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result valid right after reset");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted transaction not held in input register");

   a_stalled_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !step) |=> s1_valid_ff)
      else $error("stalled transaction dropped");

   a_read_data_zero: assert property (@(posedge clock) disable iff (reset)
      (step && s1_req_ff.kind != KIND_READ) |=> (rsp_ff.read_data == '0))
      else $error("read data nonzero for a non-read transaction");

endmodule

`default_nettype wire
